[design/arpc_pkg.sv]
// Shared types and constants of the ARP cache responder.
`default_nettype none
package arpc_pkg;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;

  // item kinds on in_tuser
  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_CACHED  = 3'd1;
  localparam logic [2:0] ST_REPLY   = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;
  localparam logic [2:0] ST_ABSENT  = 3'd5;
  localparam logic [2:0] ST_TICK    = 3'd6;

  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_IP   = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC  = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;

  localparam logic [15:0] HW_ETHERNET  = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN  = 8'd6;
  localparam logic [7:0]  IP_ADDR_LEN  = 8'd4;
  localparam logic [15:0] ARP_OP_REQ   = 16'd1;
  localparam logic [15:0] ARP_OP_REP   = 16'd2;
  localparam logic [31:0] LIFETIME_RST = 32'd6000;
  localparam logic [MacW-1:0] MAC_BCAST = {MacW{1'b1}};

  typedef struct packed {
    logic load;       // latch the accepted item, restart the scan
    logic scan_step;  // read the next cache entry
    logic commit;     // write the result, update the cache
  } arpc_cmd_t;

  typedef struct packed {
    logic need_scan;  // item must walk the cache
    logic scan_last;  // read pointer is at the final entry
    logic out_free;   // output register can take a result
  } arpc_sts_t;

endpackage
`default_nettype wire

[design/arpc_ctrl.sv]
// Controller state machine of the ARP cache responder.
`default_nettype none
module arpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire arpc_pkg::arpc_sts_t sts,
  output logic                    idle,
  output arpc_pkg::arpc_cmd_t     cmd
);
  import arpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load      = in_fire;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.need_scan) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_EVAL;
        end
      end
      S_EVAL: state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free) else $error("commit with output busy");
  a_step_needed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> sts.need_scan) else $error("scan without need");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> idle) else $error("no return to idle after commit");

endmodule
`default_nettype wire

[design/arpc_dp.sv]
// Datapath of the ARP cache responder: config, cache memory, scan and result.
`default_nettype none
module arpc_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire arpc_pkg::arpc_cmd_t cmd,
  output arpc_pkg::arpc_sts_t      sts,
  input  wire logic [1:0]          in_tuser,
  input  wire logic [207:0]        in_tdata,
  input  wire logic                cfg_valid,
  input  wire logic [1:0]          cfg_addr,
  input  wire logic [47:0]         cfg_data,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [5:0]               out_tuser,
  output logic [175:0]             out_tdata
);
  import arpc_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WordW = IpW + MacW + 32;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  logic [31:0] own_ip_r, lifetime_r, tick_r;
  logic [47:0] own_mac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r   <= '0;
      own_mac_r  <= '0;
      lifetime_r <= LIFETIME_RST;
    end else if (cfg_valid) begin
      if (cfg_addr == CFG_OWN_IP)   own_ip_r   <= cfg_data[31:0];
      if (cfg_addr == CFG_OWN_MAC)  own_mac_r  <= cfg_data;
      if (cfg_addr == CFG_LIFETIME) lifetime_r <= cfg_data[31:0];
    end
  end

  // latched item
  logic [1:0]  kind_r;
  logic        ok_r, opreq_r, need_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r, tip_r, key_r;

  wire logic [15:0] f_hw = in_tdata[15:0];
  wire logic [15:0] f_pt = in_tdata[31:16];
  wire logic [7:0]  f_hl = in_tdata[39:32];
  wire logic [7:0]  f_pl = in_tdata[47:40];
  wire logic [15:0] f_op = in_tdata[63:48];
  wire logic pkt_ok = (f_hw == HW_ETHERNET) && (f_pt == PROTO_IPV4) &&
                      (f_hl == HW_ADDR_LEN) && (f_pl == IP_ADDR_LEN) &&
                      ((f_op == ARP_OP_REQ) || (f_op == ARP_OP_REP));

  // cache storage
  logic [WordW-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [WordW-1:0] rd_word_r;
  logic [IdxW-1:0]  rd_ptr_r, rd_idx_r, wr_slot;
  logic             rd_vld_r, wr_en;

  // scan results
  logic            hit_r, free_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [47:0]     hit_mac_r;
  logic [31:0]     hit_stamp_r, best_r;

  wire logic [31:0] rd_ip    = rd_word_r[31:0];
  wire logic [47:0] rd_mac   = rd_word_r[79:32];
  wire logic [31:0] rd_stamp = rd_word_r[111:80];
  wire logic [31:0] rd_age   = tick_r - rd_stamp;
  wire logic        rd_v     = valid_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_tuser;
      ok_r    <= pkt_ok;
      opreq_r <= (f_op == ARP_OP_REQ);
      need_r  <= ((in_tuser == REQ_PACKET) && pkt_ok) || (in_tuser == REQ_LOOKUP);
      smac_r  <= in_tdata[111:64];
      sip_r   <= in_tdata[143:112];
      tip_r   <= in_tdata[175:144];
      key_r   <= (in_tuser == REQ_LOOKUP) ? in_tdata[207:176] : in_tdata[143:112];
      rd_ptr_r <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        rd_word_r <= mem[rd_ptr_r];
        rd_idx_r  <= rd_ptr_r;
        if (rd_ptr_r != LastIdx) rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (rd_v && (rd_ip == key_r) && !hit_r) begin
          hit_r       <= 1'b1;
          hit_idx_r   <= rd_idx_r;
          hit_mac_r   <= rd_mac;
          hit_stamp_r <= rd_stamp;
        end
        if (!rd_v && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
        if ((rd_idx_r == '0) || (rd_age > best_r)) begin
          best_r    <= rd_age;
          old_idx_r <= rd_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.scan_step;
  end

  // result and cache update
  logic [2:0]  st;
  logic        snd;
  logic [1:0]  op;
  logic [47:0] dst, tmac, res;
  logic [31:0] tip;
  logic        clr_en;
  wire logic   fresh = ((tick_r - hit_stamp_r) < lifetime_r);

  always_comb begin
    st = ST_IGNORED; snd = 1'b0; op = OP_NONE; dst = '0; tmac = '0; tip = '0;
    res = MAC_BCAST; wr_en = 1'b0; clr_en = 1'b0;
    wr_slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);
    unique case (kind_r)
      REQ_PACKET: begin
        if (ok_r) begin
          wr_en = 1'b1;
          st    = ST_CACHED;
          if (opreq_r && (tip_r == own_ip_r)) begin
            st = ST_REPLY; snd = 1'b1; op = OP_REPLY;
            dst = smac_r; tmac = smac_r; tip = sip_r;
          end
        end
      end
      REQ_LOOKUP: begin
        if (hit_r && fresh) begin
          st  = ST_HIT;
          res = hit_mac_r;
        end else begin
          clr_en = hit_r;
          st  = hit_r ? ST_EXPIRED : ST_ABSENT;
          snd = 1'b1; op = OP_REQUEST; dst = MAC_BCAST; tip = key_r;
        end
      end
      REQ_TICK: st = ST_TICK;
      default:  st = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) mem[wr_slot] <= {tick_r, smac_r, sip_r};
  end

  logic out_valid_r;
  logic [5:0]   out_user_r;
  logic [175:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (wr_en)  valid_r[wr_slot]   <= 1'b1;
        if (clr_en) valid_r[hit_idx_r] <= 1'b0;
        if (kind_r == REQ_TICK) tick_r <= tick_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_user_r <= {op, snd, st};
      out_data_r <= {res, tip, tmac, dst};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tuser     = out_user_r;
  assign out_tdata     = out_data_r;
  assign sts.need_scan = need_r;
  assign sts.scan_last = (rd_ptr_r == LastIdx);
  assign sts.out_free  = !out_valid_r || out_tready;

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(wr_en && clr_en)) else $error("set and clear in one commit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && !cmd.commit) |=> out_valid_r)
    else $error("result dropped");
  a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(tick_r)) else $error("time moved without tick");

endmodule
`default_nettype wire

[design/arp_cache_responder.sv]
// Top level of the ARP cache responder: controller plus datapath.
`default_nettype none
// Usage: items enter on the in_ stream. in_tuser gives the kind (packet,
// lookup or tick) and in_tdata the ARP fields. Each item yields exactly one
// result on the out_ stream: out_tuser holds status, send flag and frame
// opcode, out_tdata the frame addresses and the resolved MAC.
// Configuration (own IP, own MAC, entry lifetime) is written on the cfg_
// channel by register index; cfg_ready is always high.
// A packet that passes the format checks, or a lookup, walks all ENTRIES
// cache slots through the one read port of the cache memory, one slot per
// cycle, then passes an evaluation state before its result is committed; a
// tick or a rejected item skips the walk and goes to commit. The next item
// is taken once the controller is back in idle after the commit.
// One item is in work at a time.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the datapath holds its next result until out_tready
// frees that register, so a stalled receiver stops the block at commit.
// Reset (rst_n low, synchronous) empties the cache, zeroes the time base,
// restores the register defaults and drops any pending result.
module arp_cache_responder #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,   // req_type
  // hw_type, proto_type, hw_len, proto_len, opcode, sender_mac, sender_ip,
  // target_ip, lookup_ip
  input  wire logic [207:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [5:0]        out_tuser,  // status, send_frame, frame_op
  // eth_dst_mac, arp_target_mac, arp_target_ip, resolved_mac
  output logic [175:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [47:0]  cfg_data
);
  import arpc_pkg::*;

  arpc_cmd_t cmd;
  arpc_sts_t sts;
  logic      idle;
  wire logic in_fire = in_tvalid && in_tready;

  // accept whenever the controller is free; result register decouples
  assign in_tready = idle;
  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  arpc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[dv/arp_cache_responder_chk.sv]
// Checker for the ARP cache responder: cache predictor and result comparison.
module arp_cache_responder_chk #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [207:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [5:0]   out_tuser,
  input  logic [175:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [47:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import arpc_pkg::*;

  typedef struct packed {
    logic [2:0]      status;
    logic            send;
    logic [1:0]      op;
    logic [MacW-1:0] dst_mac;
    logic [MacW-1:0] tgt_mac;
    logic [IpW-1:0]  tgt_ip;
    logic [MacW-1:0] resolved;
  } arp_result_t;

  logic [IpW-1:0]  own_ip;
  logic [MacW-1:0] own_mac;
  logic [31:0]     lifetime;
  logic            slot_valid [ENTRIES];
  logic [IpW-1:0]  slot_ip    [ENTRIES];
  logic [MacW-1:0] slot_mac   [ENTRIES];
  logic [31:0]     slot_stamp [ENTRIES];
  logic [31:0]     ticks;
  arp_result_t     awaited_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int find_slot(logic [IpW-1:0] ip);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_ip[i] == ip) return i;
    return -1;
  endfunction

  // Work out the result of one item and update the cache copy.
  function automatic arp_result_t predict_arp(logic [1:0] kind, logic [207:0] d);
    arp_result_t     r;
    logic [15:0]     hw, proto, opc;
    logic [7:0]      hlen, plen;
    logic [MacW-1:0] smac;
    logic [IpW-1:0]  sip, tip, lip;
    logic [31:0]     age, oldest;
    int              slot;
    hw    = d[15:0];
    proto = d[31:16];
    hlen  = d[39:32];
    plen  = d[47:40];
    opc   = d[63:48];
    smac  = d[111:64];
    sip   = d[143:112];
    tip   = d[175:144];
    lip   = d[207:176];
    r          = '0;
    r.status   = ST_IGNORED;
    r.op       = OP_NONE;
    r.resolved = MAC_BCAST;
    case (kind)
      REQ_PACKET: begin
        if (hw == HW_ETHERNET && proto == PROTO_IPV4 && hlen == HW_ADDR_LEN &&
            plen == IP_ADDR_LEN && (opc == ARP_OP_REQ || opc == ARP_OP_REP)) begin
          // refresh, else lowest free slot, else evict the oldest entry
          slot = find_slot(sip);
          if (slot < 0)
            for (int i = 0; i < ENTRIES; i++)
              if (!slot_valid[i]) begin
                slot = i;
                break;
              end
          if (slot < 0) begin
            slot   = 0;
            oldest = 0;
            for (int i = 0; i < ENTRIES; i++) begin
              age = ticks - slot_stamp[i];
              if (i == 0 || age > oldest) begin
                oldest = age;
                slot   = i;
              end
            end
          end
          slot_valid[slot] = 1'b1;
          slot_ip[slot]    = sip;
          slot_mac[slot]   = smac;
          slot_stamp[slot] = ticks;
          r.status = ST_CACHED;
          if (opc == ARP_OP_REQ && tip == own_ip) begin
            r.status  = ST_REPLY;
            r.send    = 1'b1;
            r.op      = OP_REPLY;
            r.dst_mac = smac;
            r.tgt_mac = smac;
            r.tgt_ip  = sip;
          end
        end
      end
      REQ_LOOKUP: begin
        slot = find_slot(lip);
        if (slot >= 0 && (ticks - slot_stamp[slot]) < lifetime) begin
          r.status   = ST_HIT;
          r.resolved = slot_mac[slot];
        end else begin
          if (slot >= 0) begin
            slot_valid[slot] = 1'b0;
            r.status = ST_EXPIRED;
          end else begin
            r.status = ST_ABSENT;
          end
          r.send    = 1'b1;
          r.op      = OP_REQUEST;
          r.dst_mac = MAC_BCAST;
          r.tgt_ip  = lip;
        end
      end
      REQ_TICK: begin
        ticks    = ticks + 32'd1;
        r.status = ST_TICK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_result(arp_result_t e, arp_result_t a);
    if (a.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, a.status);
      errors++;
    end
    if (a.send !== e.send) begin
      $error("send_frame: expected %0d, got %0d", e.send, a.send);
      errors++;
    end
    if (a.op !== e.op) begin
      $error("frame_op: expected %0d, got %0d", e.op, a.op);
      errors++;
    end
    if (a.dst_mac !== e.dst_mac) begin
      $error("eth_dst_mac: expected %h, got %h", e.dst_mac, a.dst_mac);
      errors++;
    end
    if (a.tgt_mac !== e.tgt_mac) begin
      $error("arp_target_mac: expected %h, got %h", e.tgt_mac, a.tgt_mac);
      errors++;
    end
    if (a.tgt_ip !== e.tgt_ip) begin
      $error("arp_target_ip: expected %h, got %h", e.tgt_ip, a.tgt_ip);
      errors++;
    end
    if (a.resolved !== e.resolved) begin
      $error("resolved_mac: expected %h, got %h", e.resolved, a.resolved);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    arp_result_t seen;
    if (!rst_n) begin
      own_ip   = '0;
      own_mac  = '0;
      lifetime = LIFETIME_RST;
      ticks    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_stamp[i] = '0;
      end
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_addr)
          CFG_OWN_IP:   own_ip   = cfg_data[31:0];
          CFG_OWN_MAC:  own_mac  = cfg_data;
          CFG_LIFETIME: lifetime = cfg_data[31:0];
          default: ;
        endcase
      if (in_tvalid && in_tready)
        awaited_q.push_back(predict_arp(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        seen = {out_tuser[2:0], out_tuser[3], out_tuser[5:4], out_tdata[47:0],
                out_tdata[95:48], out_tdata[127:96], out_tdata[175:128]};
        if (awaited_q.size() == 0) begin
          $error("result with no item outstanding: status %0d", out_tuser[2:0]);
          errors++;
        end else begin
          compare_result(awaited_q.pop_front(), seen);
        end
      end
    end
    pending <= awaited_q.size();
  end

endmodule

[dv/arp_cache_responder_tb.sv]
// Testbench top for the ARP cache responder: clock, reset, stimulus and verdict.
module arp_cache_responder_tb;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam int SETTLE = ENTRIES + 10;  // cycles past the last result

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [207:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [5:0]   out_tuser;
  logic [175:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_addr = '0;
  logic [47:0]  cfg_data = '0;
  int           errors;
  int           pending;

  // receiver controls: no-idling stretch and one long hold-off
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  logic [IpW-1:0]  addr_pool [24];
  logic [IpW-1:0]  host_ip;
  logic [MacW-1:0] peer_mac;

  always #5 clk = ~clk;

  arp_cache_responder #(.ENTRIES(ENTRIES)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  arp_cache_responder_chk #(.ENTRIES(ENTRIES)) chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .errors, .pending
  );

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // Pack the ARP fields in order from bit 0; unused fields carry noise.
  function automatic logic [207:0] arp_fields(logic [15:0] hw, logic [15:0] proto,
      logic [7:0] hlen, logic [7:0] plen, logic [15:0] opc, logic [MacW-1:0] smac,
      logic [IpW-1:0] sip, logic [IpW-1:0] tip, logic [IpW-1:0] lip);
    return {lip, tip, sip, smac, opc, plen, hlen, proto, hw};
  endfunction

  function automatic logic [207:0] good_packet(logic [15:0] opc, logic [MacW-1:0] smac,
      logic [IpW-1:0] sip, logic [IpW-1:0] tip);
    return arp_fields(HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN, opc, smac,
                      sip, tip, $urandom());
  endfunction

  function automatic logic [207:0] lookup_of(logic [IpW-1:0] ip);
    return arp_fields(16'($urandom()), 16'($urandom()), 8'($urandom()), 8'($urandom()),
                      16'($urandom()), rand_mac(), $urandom(), $urandom(), ip);
  endfunction

  // Offer one item after a random gap; hold it until accepted.
  task automatic send_item(logic [1:0] kind, logic [207:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Pause the sender until every outstanding item has its result.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [IpW-1:0] ip, logic [MacW-1:0] mac, logic [31:0] life);
    drain();
    write_reg(CFG_OWN_IP, {16'd0, ip});
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_LIFETIME, {16'd0, life});
    host_ip = ip;
  endtask

  // One random item: mostly well-formed packets and lookups into a small
  // address pool so the cache fills, hits, ages out and evicts.
  task automatic random_item();
    int           pick;
    logic [207:0] d;
    logic [IpW-1:0] tip;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      tip = ($urandom_range(0, 9) < 4) ? host_ip : addr_pool[$urandom_range(0, 23)];
      d = good_packet($urandom_range(0, 1) ? ARP_OP_REQ : ARP_OP_REP, rand_mac(),
                      addr_pool[$urandom_range(0, 23)], tip);
      send_item(REQ_PACKET, d);
    end else if (pick < 57) begin
      // broken packet: corrupt one header field, or everything
      d = good_packet(ARP_OP_REQ, rand_mac(), addr_pool[$urandom_range(0, 23)], host_ip);
      case ($urandom_range(0, 5))
        0: d[15:0]  = 16'($urandom());
        1: d[31:16] = 16'($urandom());
        2: d[39:32] = 8'($urandom());
        3: d[47:40] = 8'($urandom());
        4: d[63:48] = 16'($urandom());
        default: d = {16'($urandom()), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom()};
      endcase
      send_item(REQ_PACKET, d);
    end else if (pick < 85) begin
      send_item(REQ_LOOKUP, lookup_of($urandom_range(0, 4) == 0 ? $urandom()
                                      : addr_pool[$urandom_range(0, 23)]));
    end else if (pick < 97) begin
      send_item(REQ_TICK, lookup_of($urandom()));
    end else begin
      send_item(2'd3, lookup_of($urandom()));
    end
  endtask

  // Receiver: random stall per item, one long hold-off on request.
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        stall    = 200;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [MacW-1:0] mac_a;
    logic [IpW-1:0]  ip_a;
    logic [31:0]     lifetimes [4];
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 24; i++) addr_pool[i] = $urandom();
    host_ip = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind, header checks, hit, expiry and refresh
    configure(addr_pool[5], rand_mac(), 32'd2);
    mac_a = rand_mac();
    ip_a  = addr_pool[7];
    send_item(REQ_TICK, '1);
    send_item(REQ_LOOKUP, lookup_of(ip_a));
    send_item(REQ_PACKET, good_packet(ARP_OP_REQ, mac_a, ip_a, host_ip));
    send_item(REQ_LOOKUP, lookup_of(ip_a));
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, '0);
    send_item(REQ_LOOKUP, lookup_of(ip_a));        // aged out
    send_item(REQ_LOOKUP, lookup_of(ip_a));        // now gone
    send_item(REQ_PACKET, good_packet(ARP_OP_REP, '1, '1, host_ip));
    send_item(REQ_PACKET, good_packet(ARP_OP_REQ, '0, '0, ~host_ip));
    send_item(REQ_PACKET, arp_fields(16'h0002, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                                     ARP_OP_REQ, mac_a, ip_a, host_ip, '0));
    send_item(REQ_PACKET, arp_fields(HW_ETHERNET, 16'h86dd, HW_ADDR_LEN, IP_ADDR_LEN,
                                     ARP_OP_REQ, mac_a, ip_a, host_ip, '0));
    send_item(REQ_PACKET, arp_fields(HW_ETHERNET, PROTO_IPV4, 8'hff, IP_ADDR_LEN,
                                     ARP_OP_REQ, mac_a, ip_a, host_ip, '0));
    send_item(REQ_PACKET, arp_fields(HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, 8'hff,
                                     ARP_OP_REQ, mac_a, ip_a, host_ip, '0));
    send_item(REQ_PACKET, arp_fields(HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                                     16'd0, mac_a, ip_a, host_ip, '0));
    send_item(REQ_PACKET, arp_fields(HW_ETHERNET, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                                     16'hffff, mac_a, ip_a, host_ip, '0));
    send_item(2'd3, '1);
    send_item(REQ_PACKET, good_packet(ARP_OP_REP, mac_a, ip_a, '0));
    send_item(REQ_PACKET, good_packet(ARP_OP_REP, ~mac_a, ip_a, '0));  // refresh
    send_item(REQ_LOOKUP, lookup_of(ip_a));
    send_item(REQ_LOOKUP, lookup_of('1));

    // random phases over extreme and ordinary register settings
    lifetimes[0] = 32'hffff_ffff;
    lifetimes[1] = 32'd1;
    lifetimes[2] = 32'd0;
    lifetimes[3] = 32'd6;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure(addr_pool[0], '0, lifetimes[0]);
        1: configure(addr_pool[1], '1, lifetimes[1]);
        default: configure(addr_pool[$urandom_range(2, 23)], rand_mac(), lifetimes[ph]);
      endcase
      for (int n = 0; n < 107; n++) begin
        quiet = (ph == 0 && n < 40);
        if (ph == 2 && n == 10) hold_req = 1'b1;  // receiver stalls, input backs up
        if (ph == 2 && n >= 10 && n < 30) quiet = 1'b1;
        random_item();
      end
      quiet = 1'b0;
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/arpc_pkg.sv
design/arpc_ctrl.sv
design/arpc_dp.sv
design/arp_cache_responder.sv
dv/arp_cache_responder_chk.sv
dv/arp_cache_responder_tb.sv
